/* hdl/fisr_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// fisr_pkg
// Shared constants, types and helper functions for the reciprocal square
// root pipeline.
// ============================================================================
package fisr_pkg;

    localparam logic [31:0] RSQRT_MAGIC = 32'h5f37_59df;
    localparam logic [31:0] FP_ONE_HALF = 32'h3fc0_0000;  // 1.5
    localparam logic [31:0] FP_QNAN     = 32'h7fc0_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hff;
    localparam int          TAG_W       = 33;             // {positive, guess}

    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] tag;
    } t_side;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd28;
        hit = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 5'(27 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* hdl/fisr_fmul.sv */
`timescale 1ns / 1ps
// ============================================================================
// fisr_fmul
// Four-stage single-precision multiplier, round to nearest even, subnormals
// kept. A sideband word travels with each operand pair.
// ============================================================================
module fisr_fmul
    import fisr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_side       i_side,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_side       o_side,
    output logic [31:0] o_p
);

    // stage 1: significand product
    t_side               r1_side;
    logic [47:0]         r1_p;
    logic signed [10:0]  r1_e0;
    logic                r1_sign, r1_inf, r1_zero, r1_nan;

    logic [23:0]         n_sa, n_sb;
    logic signed [10:0]  n_ea, n_eb;
    logic                n_ainf, n_binf, n_anan, n_bnan, n_azero, n_bzero;

    always_comb begin
        n_sa    = {|i_a[30:23], i_a[22:0]};
        n_sb    = {|i_b[30:23], i_b[22:0]};
        n_ea    = (i_a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, i_a[30:23]});
        n_eb    = (i_b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, i_b[30:23]});
        n_ainf  = (i_a[30:23] == EXP_MAX) && (i_a[22:0] == 23'd0);
        n_binf  = (i_b[30:23] == EXP_MAX) && (i_b[22:0] == 23'd0);
        n_anan  = (i_a[30:23] == EXP_MAX) && (i_a[22:0] != 23'd0);
        n_bnan  = (i_b[30:23] == EXP_MAX) && (i_b[22:0] != 23'd0);
        n_azero = (i_a[30:0] == 31'd0);
        n_bzero = (i_b[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.vld <= 1'b0;
        end else begin
            r1_side.vld <= i_side.vld;
        end
        r1_side.tag <= i_side.tag;
        r1_p        <= n_sa * n_sb;
        r1_e0       <= n_ea + n_eb - 11'sd126;
        r1_sign     <= i_a[31] ^ i_b[31];
        r1_inf      <= n_ainf | n_binf;
        r1_zero     <= n_azero | n_bzero;
        r1_nan      <= n_anan | n_bnan | (n_ainf & n_bzero) | (n_binf & n_azero);
    end

    // stage 2: leading zero count
    t_side               r2_side;
    logic [47:0]         r2_p;
    logic signed [10:0]  r2_e0;
    logic [5:0]          r2_lz;
    logic                r2_sign, r2_inf, r2_zero, r2_nan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.vld <= 1'b0;
        end else begin
            r2_side.vld <= r1_side.vld;
        end
        r2_side.tag <= r1_side.tag;
        r2_p        <= r1_p;
        r2_e0       <= r1_e0;
        r2_lz       <= lzc48(r1_p);
        r2_sign     <= r1_sign;
        r2_inf      <= r1_inf;
        r2_zero     <= r1_zero;
        r2_nan      <= r1_nan;
    end

    // stage 3: normalize or denormalize
    t_side               r3_side;
    logic [47:0]         r3_m;
    logic                r3_st;
    logic signed [10:0]  r3_ef;
    logic                r3_sign, r3_inf, r3_zero, r3_nan;

    logic signed [10:0]  n_e1, n_d, n_ef;
    logic [47:0]         n_m;
    logic                n_st;
    logic [10:0]         n_rs;
    logic [63:0]         n_pw;

    always_comb begin
        n_e1 = r2_e0 - $signed({5'b00000, r2_lz});
        n_d  = r2_e0 - 11'sd1;
        n_rs = 11'(-n_d);
        n_pw = {16'd0, r2_p};
        n_st = 1'b0;
        n_ef = 11'sd1;
        if (n_e1 >= 11'sd1) begin
            n_m  = r2_p << r2_lz;
            n_ef = n_e1;
        end else if (n_d >= 11'sd0) begin
            n_m  = r2_p << n_d[5:0];
        end else if (n_rs > 11'd48) begin
            n_m  = 48'd0;
            n_st = |r2_p;
        end else begin
            n_m  = r2_p >> n_rs[5:0];
            n_st = |(n_pw & ((64'd1 << n_rs[5:0]) - 64'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.vld <= 1'b0;
        end else begin
            r3_side.vld <= r2_side.vld;
        end
        r3_side.tag <= r2_side.tag;
        r3_m        <= n_m;
        r3_st       <= n_st;
        r3_ef       <= n_ef;
        r3_sign     <= r2_sign;
        r3_inf      <= r2_inf;
        r3_zero     <= r2_zero;
        r3_nan      <= r2_nan;
    end

    // stage 4: round and pack
    t_side        r4_side;
    logic [31:0]  r4_p;

    logic [23:0]  n_sig;
    logic         n_rnd;
    logic [7:0]   n_expf;
    logic [30:0]  n_mag;
    logic [31:0]  n_res;

    always_comb begin
        n_sig  = r3_m[47:24];
        n_rnd  = r3_m[23] & ((|r3_m[22:0]) | r3_st | n_sig[0]);
        n_expf = n_sig[23] ? r3_ef[7:0] : 8'd0;
        n_mag  = {n_expf, n_sig[22:0]} + {30'd0, n_rnd};
        if (r3_nan) begin
            n_res = FP_QNAN;
        end else if (r3_inf || r3_ef >= 11'sd255) begin
            n_res = {r3_sign, EXP_MAX, 23'd0};
        end else if (r3_zero) begin
            n_res = {r3_sign, 31'd0};
        end else begin
            n_res = {r3_sign, n_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side.vld <= 1'b0;
        end else begin
            r4_side.vld <= r3_side.vld;
        end
        r4_side.tag <= r3_side.tag;
        r4_p        <= n_res;
    end

    assign o_side = r4_side;
    assign o_p    = r4_p;

endmodule

/* hdl/fisr_fsub.sv */
`timescale 1ns / 1ps
// ============================================================================
// fisr_fsub
// Three-stage single-precision subtractor a - b, round to nearest even,
// subnormals kept. A sideband word travels with each operand pair.
// ============================================================================
module fisr_fsub
    import fisr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_side       i_side,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_side       o_side,
    output logic [31:0] o_d
);

    // stage 1: swap, align, add or subtract
    t_side        r1_side;
    logic [27:0]  r1_sum;
    logic [7:0]   r1_ex;
    logic         r1_sign, r1_inf, r1_isign, r1_nan;

    logic [31:0]  n_nb, n_x, n_y;
    logic [7:0]   n_ex, n_ey, n_dexp;
    logic [23:0]  n_sx, n_sy;
    logic [26:0]  n_my;
    logic         n_sty, n_sub, n_ainf, n_binf;

    always_comb begin
        n_nb  = {~i_b[31], i_b[30:0]};
        if (i_a[30:0] >= n_nb[30:0]) begin
            n_x = i_a;
            n_y = n_nb;
        end else begin
            n_x = n_nb;
            n_y = i_a;
        end
        n_ex   = (n_x[30:23] == 8'd0) ? 8'd1 : n_x[30:23];
        n_ey   = (n_y[30:23] == 8'd0) ? 8'd1 : n_y[30:23];
        n_sx   = {|n_x[30:23], n_x[22:0]};
        n_sy   = {|n_y[30:23], n_y[22:0]};
        n_dexp = n_ex - n_ey;
        if (n_dexp >= 8'd27) begin
            n_my  = 27'd0;
            n_sty = |n_sy;
        end else begin
            n_my  = {n_sy, 3'b000} >> n_dexp[4:0];
            n_sty = |({n_sy, 3'b000} & ((27'd1 << n_dexp[4:0]) - 27'd1));
        end
        n_my[0] = n_my[0] | n_sty;
        n_sub   = n_x[31] ^ n_y[31];
        n_ainf  = (i_a[30:23] == EXP_MAX) && (i_a[22:0] == 23'd0);
        n_binf  = (n_nb[30:23] == EXP_MAX) && (n_nb[22:0] == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.vld <= 1'b0;
        end else begin
            r1_side.vld <= i_side.vld;
        end
        r1_side.tag <= i_side.tag;
        r1_sum      <= n_sub ? ({1'b0, n_sx, 3'b000} - {1'b0, n_my})
                             : ({1'b0, n_sx, 3'b000} + {1'b0, n_my});
        r1_ex       <= n_ex;
        r1_sign     <= n_x[31];
        r1_inf      <= n_ainf | n_binf;
        r1_isign    <= n_ainf ? i_a[31] : n_nb[31];
        r1_nan      <= ((i_a[30:23] == EXP_MAX) && (i_a[22:0] != 23'd0))
                     | ((i_b[30:23] == EXP_MAX) && (i_b[22:0] != 23'd0))
                     | (n_ainf & n_binf & (i_a[31] != n_nb[31]));
    end

    // stage 2: leading zero count
    t_side        r2_side;
    logic [27:0]  r2_sum;
    logic [7:0]   r2_ex;
    logic [4:0]   r2_lz;
    logic         r2_sign, r2_inf, r2_isign, r2_nan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.vld <= 1'b0;
        end else begin
            r2_side.vld <= r1_side.vld;
        end
        r2_side.tag <= r1_side.tag;
        r2_sum      <= r1_sum;
        r2_ex       <= r1_ex;
        r2_lz       <= lzc28(r1_sum);
        r2_sign     <= r1_sign;
        r2_inf      <= r1_inf;
        r2_isign    <= r1_isign;
        r2_nan      <= r1_nan;
    end

    // stage 3: normalize, round, pack
    t_side        r3_side;
    logic [31:0]  r3_d;

    logic [26:0]  n_m;
    logic [9:0]   n_e;
    logic [4:0]   n_ls;
    logic [23:0]  n_sig;
    logic         n_rnd;
    logic [7:0]   n_expf;
    logic [30:0]  n_mag;
    logic [31:0]  n_res;

    always_comb begin
        n_ls = 5'd0;
        if (r2_sum[27]) begin
            n_m    = r2_sum[27:1];
            n_m[0] = r2_sum[1] | r2_sum[0];
            n_e    = {2'b00, r2_ex} + 10'd1;
        end else begin
            if ({3'b000, r2_lz} - 8'd1 < r2_ex) begin
                n_ls = r2_lz - 5'd1;
            end else begin
                n_ls = 5'(r2_ex - 8'd1);
            end
            n_m = r2_sum[26:0] << n_ls;
            n_e = {2'b00, r2_ex} - {5'd0, n_ls};
        end
        n_sig  = n_m[26:3];
        n_rnd  = n_m[2] & (n_m[1] | n_m[0] | n_sig[0]);
        n_expf = n_sig[23] ? n_e[7:0] : 8'd0;
        n_mag  = {n_expf, n_sig[22:0]} + {30'd0, n_rnd};
        if (r2_nan) begin
            n_res = FP_QNAN;
        end else if (r2_inf) begin
            n_res = {r2_isign, EXP_MAX, 23'd0};
        end else if (r2_sum == 28'd0) begin
            n_res = 32'd0;
        end else if (n_e >= 10'd255) begin
            n_res = {r2_sign, EXP_MAX, 23'd0};
        end else begin
            n_res = {r2_sign, n_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.vld <= 1'b0;
        end else begin
            r3_side.vld <= r2_side.vld;
        end
        r3_side.tag <= r2_side.tag;
        r3_d        <= n_res;
    end

    assign o_side = r3_side;
    assign o_d    = r3_d;

endmodule

/* hdl/fast_inverse_sqrt_single.sv */
`timescale 1ns / 1ps
// ============================================================================
// fast_inverse_sqrt_single
// Pipeline: input register, three 4-stage multipliers, one 3-stage
// subtractor, output register.
// Throughput: one word per cycle; busy is always low.
// Reset: synchronous, active low; clears the pipeline valid bits and the strobe.
// ============================================================================
module fast_inverse_sqrt_single
    import fisr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_bits,
    output logic        o_strobe,
    output logic [31:0] o_result_bits,
    output logic        o_valid_res
);

    logic         n_pos;
    logic [31:0]  n_half, n_guess;
    logic [23:0]  n_hsub;

    always_comb begin
        n_pos = !i_operand_bits[31] && (i_operand_bits != 32'd0)
              && !((i_operand_bits[30:23] == EXP_MAX) && (i_operand_bits[22:0] != 23'd0));
        n_hsub = {1'b0, i_operand_bits[23:1]}
               + {23'd0, i_operand_bits[1] & i_operand_bits[0]};
        if (i_operand_bits[30:23] == EXP_MAX) begin
            n_half = i_operand_bits;
        end else if (i_operand_bits[30:23] >= 8'd2) begin
            n_half = {i_operand_bits[31], i_operand_bits[30:23] - 8'd1,
                      i_operand_bits[22:0]};
        end else begin
            n_half = {i_operand_bits[31], 7'd0, n_hsub};
        end
        n_guess = RSQRT_MAGIC - {1'b0, i_operand_bits[31:1]};
    end

    t_side        r0_side;
    logic [31:0]  r0_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_side.vld <= 1'b0;
        end else begin
            r0_side.vld <= start & ~busy;
        end
        r0_side.tag <= {n_pos, n_guess};
        r0_half     <= n_half;
    end

    t_side        s1_side, s2_side, s3_side, s4_side;
    logic [31:0]  w_xy, w_xyy, w_diff, w_r;

    fisr_fmul u_mul_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r0_side),
        .i_a     (r0_half),
        .i_b     (r0_side.tag[31:0]),
        .o_side  (s1_side),
        .o_p     (w_xy)
    );

    fisr_fmul u_mul_xyy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (s1_side),
        .i_a     (w_xy),
        .i_b     (s1_side.tag[31:0]),
        .o_side  (s2_side),
        .o_p     (w_xyy)
    );

    fisr_fsub u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (s2_side),
        .i_a     (FP_ONE_HALF),
        .i_b     (w_xyy),
        .o_side  (s3_side),
        .o_d     (w_diff)
    );

    fisr_fmul u_mul_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (s3_side),
        .i_a     (s3_side.tag[31:0]),
        .i_b     (w_diff),
        .o_side  (s4_side),
        .o_p     (w_r)
    );

    logic         r_strobe, r_valid_res;
    logic [31:0]  r_result_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s4_side.vld;
        end
        r_valid_res   <= s4_side.tag[TAG_W-1];
        r_result_bits <= s4_side.tag[TAG_W-1] ? w_r : 32'd0;
    end

    assign busy          = 1'b0;
    assign o_strobe      = r_strobe;
    assign o_result_bits = r_result_bits;
    assign o_valid_res   = r_valid_res;

endmodule

/* hdl/fisr_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// fisr_assertions
// Port-level checks on the reciprocal square root pipeline, bound to the
// top level.
// ============================================================================
module fisr_assertions
    import fisr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_operand_bits,
    input  logic        o_strobe,
    input  logic [31:0] o_result_bits,
    input  logic        o_valid_res
);

    localparam int LAT = 17;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_strobe_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_result_bits == 32'd0))
        else $error("invalid result not zero");

    a_valid_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |-> !$past(i_operand_bits[31], LAT))
        else $error("valid result for negative operand");

endmodule

bind fast_inverse_sqrt_single fisr_assertions u_fisr_assertions (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operand_bits (i_operand_bits),
    .o_strobe       (o_strobe),
    .o_result_bits  (o_result_bits),
    .o_valid_res    (o_valid_res)
);
